>>> rtl/core/sos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_pkg
// Shared constants, lane types and elaboration-time helpers for the
// sum-of-sinusoids fading gain generator.
// ----------------------------------------------------------------------------
package sos_pkg;

    localparam int ROT_STEPS          = 30;
    localparam int OSC_DEFAULT        = 8;
    localparam int GAIN_WIDTH_DEFAULT = 16;

    // rotation lane widths (values stay within about 2^31)
    localparam int XW = 34;
    localparam int ZW = 34;
    // vectoring lane width
    localparam int VW = 36;

    localparam logic [31:0] ROT_GAIN_INV  = 32'h26DD3B6A;
    localparam logic [31:0] DOPPLER_RESET = 32'd10307922;

    // atan(2^-k) in 2^-32 turn
    localparam logic [31:0] TURN_ATAN [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_rot_lane;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic                 zero;
    } t_vec_lane;

    // cos or sin of an angle in 2^-32 turn, scaled by 2^30 (constant use only)
    function automatic longint rot_const(input logic [31:0] a_in, input logic want_sin);
        logic [31:0] a;
        logic [31:0] tmp;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        tmp  = a_in + 32'h40000000;
        flip = tmp[31];
        a    = flip ? (a_in + 32'h80000000) : a_in;
        z    = longint'($signed(a));
        x    = longint'(ROT_GAIN_INV);
        y    = 0;
        for (int k = 0; k < ROT_STEPS; k++) begin
            if (z >= 0) begin
                t = x - (y >>> k);
                y = y + (x >>> k);
                z = z - longint'(TURN_ATAN[k]);
            end else begin
                t = x + (y >>> k);
                y = y - (x >>> k);
                z = z + longint'(TURN_ATAN[k]);
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        return want_sin ? y : x;
    endfunction

    // floor square root (constant use only)
    function automatic longint unsigned isqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'h4000000000000000;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/sos_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_rot_cell
// One micro-rotation step applied to every oscillator lane, registered.
// ----------------------------------------------------------------------------
module sos_rot_cell #(
    parameter int LANES = 16,
    parameter int STEP  = 0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  sos_pkg::t_rot_lane i_lane [LANES],
    output sos_pkg::t_rot_lane o_lane [LANES]
);
    import sos_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(TURN_ATAN[STEP]));

    t_rot_lane r_lane [LANES];
    t_rot_lane n_lane [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_lane[l].flip = i_lane[l].flip;
            if (!i_lane[l].z[ZW-1]) begin
                n_lane[l].x = i_lane[l].x - (i_lane[l].y >>> STEP);
                n_lane[l].y = i_lane[l].y + (i_lane[l].x >>> STEP);
                n_lane[l].z = i_lane[l].z - ATAN;
            end else begin
                n_lane[l].x = i_lane[l].x + (i_lane[l].y >>> STEP);
                n_lane[l].y = i_lane[l].y - (i_lane[l].x >>> STEP);
                n_lane[l].z = i_lane[l].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

>>> rtl/core/sos_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_vec_cell
// One vectoring step of the gain phase search, registered.
// ----------------------------------------------------------------------------
module sos_vec_cell #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  sos_pkg::t_vec_lane i_lane,
    output sos_pkg::t_vec_lane o_lane
);
    import sos_pkg::*;

    localparam logic signed [VW-1:0] ATAN = $signed(VW'(TURN_ATAN[STEP]));

    t_vec_lane r_lane;
    t_vec_lane n_lane;

    always_comb begin
        n_lane.zero = i_lane.zero;
        if (!i_lane.y[VW-1]) begin
            n_lane.x = i_lane.x + (i_lane.y >>> STEP);
            n_lane.y = i_lane.y - (i_lane.x >>> STEP);
            n_lane.z = i_lane.z + ATAN;
        end else begin
            n_lane.x = i_lane.x - (i_lane.y >>> STEP);
            n_lane.y = i_lane.y + (i_lane.x >>> STEP);
            n_lane.z = i_lane.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

>>> rtl/core/sos_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_sqrt_cell
// One result bit of the envelope square root, registered.
// ----------------------------------------------------------------------------
module sos_sqrt_cell #(
    parameter int W     = 32,
    parameter int SHIFT = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_v,
    input  logic [W-1:0] i_r,
    output logic [W-1:0] o_v,
    output logic [W-1:0] o_r
);
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << SHIFT;

    logic [W-1:0] r_v;
    logic [W-1:0] r_r;
    logic [W-1:0] n_v;
    logic [W-1:0] n_r;
    logic [W-1:0] trial;

    always_comb begin
        trial = i_r + BIT;
        if (i_v >= trial) begin
            n_v = i_v - trial;
            n_r = (i_r >> 1) + BIT;
        end else begin
            n_v = i_v;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
            r_r <= n_r;
        end
    end

    assign o_v = r_v;
    assign o_r = r_r;

endmodule

>>> rtl/core/sum_of_sinusoids_fading_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_of_sinusoids_fading_gain
// Fading gain generator: one word in (sample index), one word out (I, Q,
// envelope, phase). Fully pipelined, one word per cycle while the output is
// not held. A 30-cell rotation chain forms every oscillator's cosine and
// sine, and a vectoring chain forms the phase. A held output word freezes
// the whole pipeline, so o_stall follows i_stall while o_valid is high.
// ----------------------------------------------------------------------------
module sum_of_sinusoids_fading_gain #(
    parameter int OSCILLATORS = sos_pkg::OSC_DEFAULT,
    parameter int GAIN_WIDTH  = sos_pkg::GAIN_WIDTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [31:0]                  i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [31:0]                  i_sample_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [GAIN_WIDTH-1:0] o_in_phase,
    output logic signed [GAIN_WIDTH-1:0] o_quadrature,
    output logic [GAIN_WIDTH-2:0]        o_envelope,
    output logic signed [15:0]           o_gain_phase
);
    import sos_pkg::*;

    localparam int LANES  = 2 * OSCILLATORS;
    localparam int GF     = GAIN_WIDTH - 3;
    localparam int TAILN  = (GAIN_WIDTH > ROT_STEPS) ? GAIN_WIDTH : ROT_STEPS;
    localparam int DEPTH  = 38 + TAILN;
    localparam int SW     = 37;
    localparam int PW     = (SW - 10) + 33;
    localparam int RND_SH = 51 - GF;
    localparam int EW     = 2 * GAIN_WIDTH;
    localparam int ADLY   = TAILN - ROT_STEPS;
    localparam int EDLY   = TAILN - GAIN_WIDTH;

    localparam longint unsigned R_SQ  = 64'h4000000000000000 / OSCILLATORS;
    localparam longint unsigned R_VAL = isqrt(R_SQ);
    localparam logic signed [32:0] R_S = $signed(33'(R_VAL));
    localparam logic signed [PW-1:0] RND = $signed(PW'(64'd1 << (RND_SH - 1)));
    localparam logic signed [PW-1:0] G_MAX =
        $signed(PW'((64'd1 << (GAIN_WIDTH - 1)) - 64'd1));
    localparam logic signed [PW-1:0] G_MIN = -G_MAX - 1;
    localparam logic [EW-1:0] E_MAX = EW'((64'd1 << (GAIN_WIDTH - 1)) - 64'd1);

    function automatic logic signed [GAIN_WIDTH-1:0] scale_sat(
        input logic signed [PW-1:0] prod
    );
        logic signed [PW-1:0] v;
        v = (prod + RND) >>> RND_SH;
        if (v > G_MAX) begin
            v = G_MAX;
        end else if (v < G_MIN) begin
            v = G_MIN;
        end
        return v[GAIN_WIDTH-1:0];
    endfunction

    // flow control
    logic             en;
    logic [DEPTH-1:0] r_vld;
    logic [31:0]      r_doppler;

    assign en      = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_doppler <= DOPPLER_RESET;
        end else begin
            if (en) begin
                r_vld <= {r_vld[DEPTH-2:0], i_valid};
            end
            if (i_cfg_wr_en) begin
                r_doppler <= i_cfg_wr_data;
            end
        end
    end

    // total phase
    logic [63:0] n_p;
    logic [63:0] r_p;

    assign n_p = r_doppler * i_sample_index;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    // oscillator phases, split product modulo one turn
    logic [31:0] r_lo    [LANES];
    logic [30:0] r_hi    [LANES];
    logic [31:0] r_phase [LANES];
    t_rot_lane   rot     [ROT_STEPS+1][LANES];

    for (genvar L = 0; L < LANES; L++) begin : g_lane
        localparam int IDX = L % OSCILLATORS;
        localparam logic signed [31:0] C =
            32'(rot_const(32'((4 * IDX + 1) * (2 ** 25)), (L >= OSCILLATORS)));

        logic signed [63:0] lo_full;
        logic signed [63:0] hi_full;
        logic [31:0]        tmp;
        logic               flip;
        logic [31:0]        a;

        assign lo_full = $signed({1'b0, r_p[30:0]}) * C;
        assign hi_full = $signed({1'b0, r_p[61:31]}) * C;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lo[L]    <= lo_full[61:30];
                r_hi[L]    <= hi_full[30:0];
                r_phase[L] <= r_lo[L] + {r_hi[L], 1'b0};
            end
        end

        assign tmp  = r_phase[L] + 32'h40000000;
        assign flip = tmp[31];
        assign a    = flip ? (r_phase[L] + 32'h80000000) : r_phase[L];

        assign rot[0][L].x    = $signed(XW'(ROT_GAIN_INV));
        assign rot[0][L].y    = '0;
        assign rot[0][L].z    = ZW'($signed(a));
        assign rot[0][L].flip = flip;
    end

    for (genvar k = 0; k < ROT_STEPS; k++) begin : g_rot
        sos_rot_cell #(
            .LANES(LANES),
            .STEP (k)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_lane(rot[k]),
            .o_lane(rot[k+1])
        );
    end

    // sums and scaling
    logic signed [SW-1:0]     n_sum_i;
    logic signed [SW-1:0]     n_sum_q;
    logic signed [SW-1:0]     r_sum_i;
    logic signed [SW-1:0]     r_sum_q;
    logic signed [PW-1:0]     r_prod_i;
    logic signed [PW-1:0]     r_prod_q;
    logic signed [GAIN_WIDTH-1:0] r_gi;
    logic signed [GAIN_WIDTH-1:0] r_gq;

    always_comb begin
        n_sum_i = '0;
        n_sum_q = '0;
        for (int l = 0; l < OSCILLATORS; l++) begin
            n_sum_i = n_sum_i + (rot[ROT_STEPS][l].flip ?
                -SW'(rot[ROT_STEPS][l].x) : SW'(rot[ROT_STEPS][l].x));
            n_sum_q = n_sum_q + (rot[ROT_STEPS][l+OSCILLATORS].flip ?
                -SW'(rot[ROT_STEPS][l+OSCILLATORS].y) :
                SW'(rot[ROT_STEPS][l+OSCILLATORS].y));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum_i  <= n_sum_i;
            r_sum_q  <= n_sum_q;
            r_prod_i <= $signed(r_sum_i[SW-1:10]) * R_S;
            r_prod_q <= $signed(r_sum_q[SW-1:10]) * R_S;
            r_gi     <= scale_sat(r_prod_i);
            r_gq     <= scale_sat(r_prod_q);
        end
    end

    // envelope
    logic signed [EW-1:0] sq_i;
    logic signed [EW-1:0] sq_q;
    logic [EW-1:0]        r_e2;
    logic [EW-1:0]        sq_v [GAIN_WIDTH+1];
    logic [EW-1:0]        sq_r [GAIN_WIDTH+1];

    assign sq_i = r_gi * r_gi;
    assign sq_q = r_gq * r_gq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e2 <= $unsigned(sq_i) + $unsigned(sq_q);
        end
    end

    assign sq_v[0] = r_e2;
    assign sq_r[0] = '0;

    for (genvar j = 0; j < GAIN_WIDTH; j++) begin : g_sqrt
        sos_sqrt_cell #(
            .W    (EW),
            .SHIFT(2 * (GAIN_WIDTH - 1 - j))
        ) u_cell (
            .i_clk(i_clk),
            .i_en (en),
            .i_v  (sq_v[j]),
            .i_r  (sq_r[j]),
            .o_v  (sq_v[j+1]),
            .o_r  (sq_r[j+1])
        );
    end

    // phase
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    t_vec_lane            r_vprep;
    t_vec_lane            vec [ROT_STEPS+1];

    assign vx = VW'(r_gi) <<< (32 - GAIN_WIDTH);
    assign vy = VW'(r_gq) <<< (32 - GAIN_WIDTH);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vprep.zero <= (r_gi == '0) && (r_gq == '0);
            if (vx[VW-1]) begin
                r_vprep.x <= -vx;
                r_vprep.y <= -vy;
                r_vprep.z <= $signed(VW'(64'h80000000));
            end else begin
                r_vprep.x <= vx;
                r_vprep.y <= vy;
                r_vprep.z <= '0;
            end
        end
    end

    assign vec[0] = r_vprep;

    for (genvar k = 0; k < ROT_STEPS; k++) begin : g_vec
        sos_vec_cell #(
            .STEP(k)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_lane(vec[k]),
            .o_lane(vec[k+1])
        );
    end

    // alignment
    logic signed [GAIN_WIDTH-1:0] gi_d [TAILN+2];
    logic signed [GAIN_WIDTH-1:0] gq_d [TAILN+2];
    t_vec_lane                    ang_d [ADLY+1];
    logic [EW-1:0]                ev_d [EDLY+1];
    logic [EW-1:0]                er_d [EDLY+1];

    assign gi_d[0]  = r_gi;
    assign gq_d[0]  = r_gq;
    assign ang_d[0] = vec[ROT_STEPS];
    assign ev_d[0]  = sq_v[GAIN_WIDTH];
    assign er_d[0]  = sq_r[GAIN_WIDTH];

    for (genvar k = 1; k < TAILN + 2; k++) begin : g_gdly
        always_ff @(posedge i_clk) begin
            if (en) begin
                gi_d[k] <= gi_d[k-1];
                gq_d[k] <= gq_d[k-1];
            end
        end
    end

    for (genvar k = 1; k < ADLY + 1; k++) begin : g_adly
        always_ff @(posedge i_clk) begin
            if (en) begin
                ang_d[k] <= ang_d[k-1];
            end
        end
    end

    for (genvar k = 1; k < EDLY + 1; k++) begin : g_edly
        always_ff @(posedge i_clk) begin
            if (en) begin
                ev_d[k] <= ev_d[k-1];
                er_d[k] <= er_d[k-1];
            end
        end
    end

    // output word
    logic [EW-1:0]        env_r;
    logic [EW-1:0]        env;
    logic signed [VW-1:0] ph_sum;
    logic signed [15:0]   ph;

    always_comb begin
        env_r = er_d[EDLY] + ((ev_d[EDLY] > er_d[EDLY]) ? EW'(1) : EW'(0));
        env   = (env_r > E_MAX) ? E_MAX : env_r;
        ph_sum = ang_d[ADLY].z + $signed(VW'(32768));
        ph     = ang_d[ADLY].zero ? 16'sd0 : ph_sum[31:16];
    end

    logic signed [GAIN_WIDTH-1:0] r_out_i;
    logic signed [GAIN_WIDTH-1:0] r_out_q;
    logic [GAIN_WIDTH-2:0]        r_out_env;
    logic signed [15:0]           r_out_ph;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_i   <= gi_d[TAILN+1];
            r_out_q   <= gq_d[TAILN+1];
            r_out_env <= env[GAIN_WIDTH-2:0];
            r_out_ph  <= ph;
        end
    end

    assign o_in_phase   = r_out_i;
    assign o_quadrature = r_out_q;
    assign o_envelope   = r_out_env;
    assign o_gain_phase = r_out_ph;

endmodule

>>> rtl/core/sos_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_checker
// Port-level checks on the fading gain generator, bound to the top level.
// ----------------------------------------------------------------------------
module sos_checker #(
    parameter int GAIN_WIDTH = sos_pkg::GAIN_WIDTH_DEFAULT
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [GAIN_WIDTH-1:0] o_in_phase,
    input logic signed [GAIN_WIDTH-1:0] o_quadrature,
    input logic [GAIN_WIDTH-2:0]        o_envelope,
    input logic signed [15:0]           o_gain_phase
);
    // held output word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_in_phase) && $stable(o_quadrature)
            && $stable(o_envelope) && $stable(o_gain_phase))
        else $error("output word changed while stalled");

    // empty output never back-pressures
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with output empty");

    // zero gain gives zero phase and envelope
    a_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_in_phase == '0) && (o_quadrature == '0) |-> o_gain_phase == '0)
        else $error("nonzero phase for zero gain");

    a_zero_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_in_phase == '0) && (o_quadrature == '0) |-> o_envelope == '0)
        else $error("nonzero envelope for zero gain");

endmodule

bind sum_of_sinusoids_fading_gain sos_checker #(
    .GAIN_WIDTH(GAIN_WIDTH)
) u_sos_checker (.*);

>>> bench/gain_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_checker
// Watches the register port and both word channels of the fading gain
// generator. Works out the I, Q, envelope and phase of every accepted sample
// index and compares them, in order, with the words that come out.
// ----------------------------------------------------------------------------
module gain_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [31:0]        i_sample_index,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_in_phase,
    input  logic signed [15:0] i_quadrature,
    input  logic [14:0]        i_envelope,
    input  logic signed [15:0] i_gain_phase,
    output int                 o_fail_count,
    output int                 o_pending
);

    import sos_pkg::*;

    localparam int N_OSC = 8;

    typedef struct {
        logic signed [15:0] in_phase;
        logic signed [15:0] quadrature;
        logic [14:0]        envelope;
        logic signed [15:0] gain_phase;
    } t_gain_word;

    t_gain_word  gain_q[$];
    logic [31:0] doppler_step;
    longint      angle_cos [N_OSC];
    longint      angle_sin [N_OSC];
    longint      root_scale;

    function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                    output longint s);
        logic [31:0] a;
        logic [31:0] tmp;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        tmp  = ang + 32'h40000000;
        flip = tmp[31];
        a    = flip ? ang + 32'h80000000 : ang;
        z    = longint'($signed(a));
        x    = longint'(ROT_GAIN_INV);
        y    = 0;
        for (int k = 0; k < ROT_STEPS; k++) begin
            if (z >= 0) begin
                t = x - (y >>> k);
                y = y + (x >>> k);
                z = z - longint'(TURN_ATAN[k]);
            end else begin
                t = x + (y >>> k);
                y = y - (x >>> k);
                z = z + longint'(TURN_ATAN[k]);
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint arc_of(input longint xi, input longint yi);
        longint x;
        longint y;
        longint z;
        longint t;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd1 <<< 31;
        end
        for (int k = 0; k < ROT_STEPS; k++) begin
            if (y >= 0) begin
                t = x + (y >>> k);
                y = y - (x >>> k);
                z = z + longint'(TURN_ATAN[k]);
            end else begin
                t = x - (y >>> k);
                y = y + (x >>> k);
                z = z - longint'(TURN_ATAN[k]);
            end
            x = t;
        end
        return z;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'h4000000000000000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] wrap_phase(input longint unsigned p,
                                               input longint c);
        longint unsigned prod;
        prod = p * longint'(unsigned'(c));
        return prod[61:30];
    endfunction

    function automatic longint scaled_gain(input longint s);
        longint v;
        v = (s >>> 10) * root_scale + (64'sd1 <<< 37);
        v = v >>> 38;
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_gain_word fading_gain(input logic [31:0] idx);
        t_gain_word      w;
        longint unsigned p;
        longint          sum_i;
        longint          sum_q;
        longint          c;
        longint          s;
        longint          gi;
        longint          gq;
        longint unsigned e2;
        longint unsigned env;
        longint          ph;
        p     = longint'(doppler_step) * longint'(idx);
        sum_i = 0;
        sum_q = 0;
        for (int i = 0; i < N_OSC; i++) begin
            sin_cos(wrap_phase(p, angle_cos[i]), c, s);
            sum_i += c;
            sin_cos(wrap_phase(p, angle_sin[i]), c, s);
            sum_q += s;
        end
        gi  = scaled_gain(sum_i);
        gq  = scaled_gain(sum_q);
        e2  = gi * gi + gq * gq;
        env = root_floor(e2);
        if (e2 - env * env > env) env++;
        if (env > 32767) env = 32767;
        if (gi == 0 && gq == 0) ph = 0;
        else ph = (arc_of(gi <<< 16, gq <<< 16) + 32768) >>> 16;
        w.in_phase   = gi[15:0];
        w.quadrature = gq[15:0];
        w.envelope   = env[14:0];
        w.gain_phase = ph[15:0];
        return w;
    endfunction

    initial begin
        for (int i = 0; i < N_OSC; i++) begin
            sin_cos(32'((4 * i + 1) << 25), angle_cos[i], angle_sin[i]);
        end
        root_scale = longint'(root_floor((64'd1 << 62) / N_OSC));
    end

    assign o_pending = gain_q.size();

    always @(posedge i_clk) begin
        t_gain_word exp_w;
        if (!i_rst_n) begin
            doppler_step = DOPPLER_RESET;
            o_fail_count = 0;
            gain_q.delete();
        end else begin
            if (i_valid && !i_in_stall) gain_q.push_back(fading_gain(i_sample_index));
            if (i_cfg_wr_en) doppler_step = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall) begin
                if (gain_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected word: I %0d Q %0d env %0d ph %0d",
                                 i_in_phase, i_quadrature, i_envelope, i_gain_phase);
                end else begin
                    exp_w = gain_q.pop_front();
                    if (exp_w.in_phase !== i_in_phase || exp_w.quadrature !== i_quadrature
                        || exp_w.envelope !== i_envelope
                        || exp_w.gain_phase !== i_gain_phase) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"word mismatch: exp I %0d Q %0d env %0d ph %0d,",
                                      " got I %0d Q %0d env %0d ph %0d"},
                                     exp_w.in_phase, exp_w.quadrature, exp_w.envelope,
                                     exp_w.gain_phase, i_in_phase, i_quadrature,
                                     i_envelope, i_gain_phase);
                    end
                end
            end
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample indices through the fading gain generator under several
// Doppler step settings, with random gaps and output back-pressure, one long
// hold-off to fill the pipeline, and a final verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY  = 80;
    localparam int WD_LIMIT = 20000;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_wr_en    = 1'b0;
    logic [31:0]        i_cfg_wr_data  = '0;
    logic               i_valid        = 1'b0;
    logic [31:0]        i_sample_index = '0;
    logic               i_stall        = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic signed [15:0] o_in_phase;
    logic signed [15:0] o_quadrature;
    logic [14:0]        o_envelope;
    logic signed [15:0] o_gain_phase;
    int                 fail_count;
    int                 pending;

    bit  sink_quiet  = 1'b0;
    bit  src_quiet   = 1'b0;
    bit  want_hold   = 1'b0;
    bit  hold_done   = 1'b0;
    int  hold_cnt    = 0;
    int  idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    sum_of_sinusoids_fading_gain dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_index (i_sample_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_in_phase     (o_in_phase),
        .o_quadrature   (o_quadrature),
        .o_envelope     (o_envelope),
        .o_gain_phase   (o_gain_phase)
    );

    gain_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .i_in_stall     (o_stall),
        .i_sample_index (i_sample_index),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_in_phase     (o_in_phase),
        .i_quadrature   (o_quadrature),
        .i_envelope     (o_envelope),
        .i_gain_phase   (o_gain_phase),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (want_hold && !hold_done) begin
            hold_cnt  = 400;
            hold_done = 1'b1;
        end
        if (hold_cnt > 0) begin
            i_stall <= 1'b1;
            hold_cnt--;
        end else if (sink_quiet) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            hold_cnt = $urandom_range(10, 50);
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_index(input logic [31:0] idx);
        int g;
        i_valid        <= 1'b1;
        i_sample_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        g = src_quiet ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [31:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] steps [7];
        logic [31:0] ramp;
        int          r;
        steps = '{32'd10307922, 32'd0, 32'hFFFFFFFF, 32'd1, 32'h80000000,
                  32'd0, 32'd0};
        steps[5] = $urandom();
        steps[6] = $urandom_range(0, 32'h00FFFFFF);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset step, then zero, 0x80000000 and 0xFFFFFFFF steps
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'hFFFFFFFF);
        send_index(32'h80000000);
        send_index(32'h7FFFFFFF);
        send_index(32'h55555555);
        send_index(32'hAAAAAAAA);
        send_index(32'd417);
        drain();
        write_step(32'd0);
        send_index(32'hFFFFFFFF);
        send_index(32'd12345);
        drain();
        write_step(32'h80000000);
        for (int i = 0; i < 6; i++) send_index(32'(i));
        drain();
        write_step(32'hFFFFFFFF);
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'hFFFFFFFF);
        send_index(32'h0000FFFF);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            write_step(steps[ph]);
            sink_quiet = (ph == 3);
            src_quiet  = (ph == 2 || ph == 3);
            if (ph == 2) want_hold = 1'b1;
            ramp = $urandom();
            for (int n = 0; n < 260; n++) begin
                r = $urandom_range(0, 9);
                if (r < 4) send_index($urandom());
                else if (r < 7) send_index($urandom_range(0, 4095));
                else begin
                    send_index(ramp);
                    ramp++;
                end
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
